// ===== rtl/jfs_pkg.sv =====
package jfs_pkg;

	localparam int LENGTH_BITS = 24;
	localparam int MAX_COMPONENTS = 3;

	localparam logic [7:0] MK_FILL = 8'hff;
	localparam logic [7:0] MK_SOI = 8'hd8;
	localparam logic [7:0] MK_EOI = 8'hd9;
	localparam logic [7:0] MK_SOS = 8'hda;
	localparam logic [7:0] MK_SOF0 = 8'hc0;
	localparam logic [7:0] MK_RST_LO = 8'hd0;
	localparam logic [7:0] MK_RST_HI = 8'hd7;

	typedef enum logic [1:0] {
		HS_SEARCH = 2'd0,
		HS_IN_SOF = 2'd1,
		HS_VALID = 2'd2,
		HS_DONE = 2'd3
	} jfs_hdr_t;

	// controller to datapath, one set per accepted word
	typedef struct packed {
		logic flush;
		logic step;
		logic start;
		logic count;
		logic sos_mark;
		logic other_mark;
		logic len_hi;
		logic len_lo;
		logic payload;
		logic sof_cap;
		logic end_seg;
	} jfs_cmd_t;

	typedef struct packed {
		logic [7:0] x;
		logic [7:0] l1;
		logic [7:0] l2;
		logic len_small;
		logic seg_small;
	} jfs_stat_t;

	typedef struct packed {
		logic in_frame;
		logic start;
		logic fend;
		logic abort;
		logic lost;
	} jfs_flags_t;

endpackage

// ===== rtl/jfs_datapath.sv =====
module jfs_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [7:0]                        in_byte,
	input  jfs_pkg::jfs_cmd_t                 cmd,
	output jfs_pkg::jfs_stat_t                stat,
	output logic [jfs_pkg::LENGTH_BITS-1:0]   count_d,
	output jfs_pkg::jfs_hdr_t                 hdr_d,
	output logic [15:0]                       width_d,
	output logic [15:0]                       height_d,
	output logic [2:0]                        format_d
);

	localparam logic [jfs_pkg::LENGTH_BITS-1:0] CNT_MAX = '1;

	logic [7:0] dly_q [3];
	logic [15:0] seg_q, seg_d;
	logic [jfs_pkg::LENGTH_BITS-1:0] cnt_q;
	jfs_pkg::jfs_hdr_t hs_q;
	logic [3:0] idx_q, idx_d;
	logic [1:0] cc_q, cc_d;
	logic [7:0] sf_q [jfs_pkg::MAX_COMPONENTS];
	logic [7:0] sf_d [jfs_pkg::MAX_COMPONENTS];
	logic [15:0] w_q, h_q;
	logic [2:0] f_q;
	logic [15:0] len_full;

	// ratio of luma to chroma sampling area, by compares instead of a divide
	function automatic logic [2:0] derive_fmt(input logic [1:0] cc, input logic [7:0] s0,
			input logic [7:0] s1);
		logic [7:0] a, b;
		logic [10:0] a_x, b1, b2, b3, b4, b5;
		logic [2:0] r;
		a = s0[7:4] * s0[3:0];
		b = s1[7:4] * s1[3:0];
		a_x = {3'd0, a};
		b1 = {3'd0, b};
		b2 = {2'd0, b, 1'b0};
		b3 = b1 + b2;
		b4 = {1'b0, b, 2'b0};
		b5 = b4 + b1;
		r = 3'd0;
		if (cc == 2'd1 || b == 8'd0) begin
			r = 3'd0;
		end else if (a_x >= b4 && a_x < b5 && s0[3:0] == 4'd2) begin
			r = 3'd1;
		end else if (a_x >= b4 && a_x < b5 && s0[3:0] == 4'd4) begin
			r = 3'd2;
		end else if (a_x >= b2 && a_x < b3) begin
			r = 3'd3;
		end else if (a_x >= b1 && a_x < b2) begin
			r = 3'd4;
		end
		return r;
	endfunction

	assign len_full = {seg_q[15:8], dly_q[0]};
	assign stat.x = dly_q[0];
	assign stat.l1 = dly_q[1];
	assign stat.l2 = dly_q[2];
	assign stat.len_small = len_full <= 16'd2;
	assign stat.seg_small = seg_q <= 16'd1;

	always_comb begin
		logic done;
		logic [3:0] last_idx;
		done = 1'b0;
		last_idx = 4'(5 + 3 * cc_q);
		hdr_d = hs_q;
		idx_d = idx_q;
		cc_d = cc_q;
		sf_d = sf_q;
		width_d = w_q;
		height_d = h_q;
		format_d = f_q;
		seg_d = seg_q;
		count_d = cnt_q;
		if (cmd.step) begin
			if (cmd.start) begin
				count_d = {{(jfs_pkg::LENGTH_BITS-1){1'b0}}, 1'b1};
				hdr_d = jfs_pkg::HS_SEARCH;
				idx_d = 4'd0;
				seg_d = 16'd0;
			end else if (cmd.count && cnt_q != CNT_MAX) begin
				count_d = cnt_q + 1'b1;
			end
			if (cmd.sos_mark && hs_q == jfs_pkg::HS_SEARCH) begin
				hdr_d = jfs_pkg::HS_DONE;
			end
			if (cmd.other_mark && dly_q[0] == jfs_pkg::MK_SOF0 && hs_q == jfs_pkg::HS_SEARCH) begin
				hdr_d = jfs_pkg::HS_IN_SOF;
				idx_d = 4'd0;
			end
			if (cmd.len_hi) begin
				seg_d = {dly_q[0], 8'd0};
			end
			if (cmd.len_lo) begin
				seg_d = (len_full >= 16'd2) ? len_full - 16'd2 : 16'd0;
			end
			if (cmd.payload) begin
				if (seg_q != 16'd0) begin
					seg_d = seg_q - 16'd1;
				end
				if (cmd.sof_cap && hs_q == jfs_pkg::HS_IN_SOF) begin
					unique case (idx_q)
						4'd1: height_d[15:8] = dly_q[0];
						4'd2: height_d[7:0] = dly_q[0];
						4'd3: width_d[15:8] = dly_q[0];
						4'd4: width_d[7:0] = dly_q[0];
						4'd5: begin
							if (dly_q[0] != 8'd1 && dly_q[0] != 8'd3) begin
								hdr_d = jfs_pkg::HS_DONE;
								done = 1'b1;
							end else begin
								cc_d = dly_q[0][1:0];
							end
						end
						4'd7: sf_d[0] = dly_q[0];
						4'd10: sf_d[1] = dly_q[0];
						4'd13: sf_d[2] = dly_q[0];
						default: ;
					endcase
					if (!done) begin
						if (idx_q >= 4'd6 && idx_q == last_idx) begin
							format_d = derive_fmt(cc_d, sf_d[0], sf_d[1]);
							hdr_d = jfs_pkg::HS_VALID;
						end else begin
							idx_d = idx_q + 4'd1;
						end
					end
				end
			end
			if (cmd.end_seg && hdr_d == jfs_pkg::HS_IN_SOF) begin
				hdr_d = jfs_pkg::HS_DONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly_q <= '{default: 8'd0};
			seg_q <= 16'd0;
			cnt_q <= '0;
			hs_q <= jfs_pkg::HS_SEARCH;
			idx_q <= 4'd0;
			cc_q <= 2'd0;
			sf_q <= '{default: 8'd0};
			w_q <= 16'd0;
			h_q <= 16'd0;
			f_q <= 3'd0;
		end else if (cmd.flush) begin
			dly_q <= '{default: 8'd0};
			seg_q <= 16'd0;
			cnt_q <= '0;
			hs_q <= jfs_pkg::HS_SEARCH;
			idx_q <= 4'd0;
			cc_q <= 2'd0;
			sf_q <= '{default: 8'd0};
		end else if (cmd.step) begin
			dly_q <= '{dly_q[1], dly_q[2], in_byte};
			seg_q <= seg_d;
			cnt_q <= count_d;
			hs_q <= hdr_d;
			idx_q <= idx_d;
			cc_q <= cc_d;
			sf_q <= sf_d;
			w_q <= width_d;
			h_q <= height_d;
			f_q <= format_d;
		end
	end

endmodule

// ===== rtl/jfs_ctrl.sv =====
module jfs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic                 flush,
	input  jfs_pkg::jfs_stat_t   stat,
	output jfs_pkg::jfs_cmd_t    cmd,
	output jfs_pkg::jfs_flags_t  flags
);

	typedef enum logic [3:0] {
		PH_HUNT,
		PH_SOI2,
		PH_MARK,
		PH_MCODE,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_PAYLOAD,
		PH_SOS_LEN_HI,
		PH_SOS_LEN_LO,
		PH_SOS_PAYLOAD,
		PH_ENTROPY,
		PH_STUFF
	} phase_t;

	phase_t state_q, ph, nxt;
	logic resync_q, resync_d;

	always_comb begin
		cmd = '0;
		flags = '0;
		cmd.step = step;
		cmd.flush = flush;
		resync_d = resync_q;
		ph = state_q;
		// SOI seen where a marker may stand
		if ((state_q == PH_MARK || state_q == PH_MCODE || state_q == PH_ENTROPY) &&
				stat.x == jfs_pkg::MK_FILL && stat.l1 == jfs_pkg::MK_SOI) begin
			flags.abort = step;
			ph = PH_HUNT;
		end
		nxt = ph;
		if (ph == PH_HUNT) begin
			if (stat.x == jfs_pkg::MK_FILL && stat.l1 == jfs_pkg::MK_SOI &&
					stat.l2 == jfs_pkg::MK_FILL) begin
				flags.start = step;
				flags.in_frame = step;
				cmd.start = 1'b1;
				resync_d = 1'b0;
				nxt = PH_SOI2;
			end
		end else begin
			flags.in_frame = step;
			cmd.count = 1'b1;
			unique case (ph)
				PH_SOI2: nxt = PH_MARK;
				PH_MARK: begin
					if (stat.x == jfs_pkg::MK_FILL) begin
						nxt = PH_MCODE;
					end else if (!resync_q) begin
						flags.lost = step;
						resync_d = 1'b1;
					end
				end
				PH_MCODE: begin
					if (stat.x != jfs_pkg::MK_FILL) begin
						resync_d = 1'b0;
						if (stat.x == jfs_pkg::MK_EOI) begin
							flags.fend = step;
							nxt = PH_HUNT;
						end else if (stat.x >= jfs_pkg::MK_RST_LO &&
								stat.x <= jfs_pkg::MK_RST_HI) begin
							nxt = PH_ENTROPY;
						end else if (stat.x == jfs_pkg::MK_SOS) begin
							cmd.sos_mark = 1'b1;
							nxt = PH_SOS_LEN_HI;
						end else begin
							cmd.other_mark = 1'b1;
							nxt = PH_LEN_HI;
						end
					end
				end
				PH_LEN_HI: begin
					cmd.len_hi = 1'b1;
					nxt = PH_LEN_LO;
				end
				PH_SOS_LEN_HI: begin
					cmd.len_hi = 1'b1;
					nxt = PH_SOS_LEN_LO;
				end
				PH_LEN_LO: begin
					cmd.len_lo = 1'b1;
					cmd.end_seg = stat.len_small;
					nxt = stat.len_small ? PH_MARK : PH_PAYLOAD;
				end
				PH_SOS_LEN_LO: begin
					cmd.len_lo = 1'b1;
					cmd.end_seg = stat.len_small;
					nxt = stat.len_small ? PH_ENTROPY : PH_SOS_PAYLOAD;
				end
				PH_PAYLOAD: begin
					cmd.payload = 1'b1;
					cmd.sof_cap = 1'b1;
					cmd.end_seg = stat.seg_small;
					if (stat.seg_small) begin
						nxt = PH_MARK;
					end
				end
				PH_SOS_PAYLOAD: begin
					cmd.payload = 1'b1;
					cmd.end_seg = stat.seg_small;
					if (stat.seg_small) begin
						nxt = PH_ENTROPY;
					end
				end
				PH_ENTROPY: begin
					if (stat.x == jfs_pkg::MK_FILL) begin
						nxt = (stat.l1 == 8'd0) ? PH_STUFF : PH_MCODE;
					end
				end
				default: nxt = PH_ENTROPY;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_HUNT;
			resync_q <= 1'b0;
		end else if (flush) begin
			state_q <= PH_HUNT;
			resync_q <= 1'b0;
		end else if (step) begin
			state_q <= nxt;
			resync_q <= resync_d;
		end
	end

	a_start_soi2: assert property (@(posedge clk) disable iff (!arst_n)
		flags.start |=> state_q == PH_SOI2)
		else $error("frame start did not move to soi2");
	a_flush_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		flush |=> (state_q == PH_HUNT && !resync_q))
		else $error("flush left parse state");
	a_start_end: assert property (@(posedge clk) disable iff (!arst_n)
		!(flags.start && flags.fend))
		else $error("start and end on one word");
	a_lost_mark: assert property (@(posedge clk) disable iff (!arst_n)
		flags.lost |-> (state_q == PH_MARK && !resync_q))
		else $error("lost sync outside marker phase");

endmodule

// ===== rtl/jpeg_frame_splitter.sv =====
// JPEG frame splitter: takes one stream byte per word and returns one word per input word,
// carrying the byte from three data words earlier with frame start, end, abort and lost-sync
// flags, the frame length on the end word, and the SOF0 size and chroma format. The parse
// state machine and header capture advance once per accepted byte, the result is registered
// and offered the cycle after, and a new word is taken whenever the output register is
// empty or its word is being read in that cycle. A word with tuser set flushes the parser
// and returns all zeros.
module jpeg_frame_splitter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // data_byte
	input  logic        s_tuser,  // mode (flush)
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // byte_out, frame_length, header_valid, image_width,
	                              // image_height, chroma_format, zero fill
	output logic        m_tlast,  // frame_end
	output logic [3:0]  m_tuser   // in_frame, frame_start, frame_abort, lost_sync
);

	logic accept;
	jfs_pkg::jfs_cmd_t cmd;
	jfs_pkg::jfs_stat_t stat;
	jfs_pkg::jfs_flags_t flags;
	logic [jfs_pkg::LENGTH_BITS-1:0] count_d;
	jfs_pkg::jfs_hdr_t hdr_d;
	logic [15:0] width_d, height_d;
	logic [2:0] format_d;
	logic out_valid_q;
	logic [71:0] tdata_q;
	logic tlast_q;
	logic [3:0] tuser_q;
	logic [71:0] tdata_d;

	assign s_tready = !out_valid_q || m_tready;
	assign accept = s_tvalid && s_tready;

	jfs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (accept && !s_tuser),
		.flush  (accept && s_tuser),
		.stat   (stat),
		.cmd    (cmd),
		.flags  (flags)
	);

	jfs_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_byte  (s_tdata),
		.cmd      (cmd),
		.stat     (stat),
		.count_d  (count_d),
		.hdr_d    (hdr_d),
		.width_d  (width_d),
		.height_d (height_d),
		.format_d (format_d)
	);

	always_comb begin
		tdata_d = '0;
		if (!s_tuser) begin
			tdata_d[7:0] = stat.x;
			tdata_d[31:8] = flags.fend ? count_d : '0;
			if (flags.in_frame) begin
				tdata_d[32] = hdr_d == jfs_pkg::HS_VALID;
				tdata_d[48:33] = width_d;
				tdata_d[64:49] = height_d;
				tdata_d[67:65] = format_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tdata_q <= tdata_d;
			tlast_q <= flags.fend;
			tuser_q <= {flags.lost, flags.abort, flags.start, flags.in_frame};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = tdata_q;
	assign m_tlast = tlast_q;
	assign m_tuser = tuser_q;

endmodule

// ===== test/tb_top.sv =====
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	// parser phases
	localparam logic [4:0] P_HUNT = 5'd0;
	localparam logic [4:0] P_SOI2 = 5'd1;
	localparam logic [4:0] P_MARK = 5'd2;
	localparam logic [4:0] P_MCODE = 5'd3;
	localparam logic [4:0] P_LEN_HI = 5'd4;
	localparam logic [4:0] P_LEN_LO = 5'd5;
	localparam logic [4:0] P_PAYLOAD = 5'd6;
	localparam logic [4:0] P_SOS_LEN_HI = 5'd7;
	localparam logic [4:0] P_SOS_LEN_LO = 5'd8;
	localparam logic [4:0] P_SOS_PAYLOAD = 5'd9;
	localparam logic [4:0] P_ENTROPY = 5'd10;
	localparam logic [4:0] P_STUFF = 5'd11;

	localparam logic [7:0] MK_APP0 = 8'he0;
	localparam logic [7:0] MK_DQT = 8'hdb;

	localparam logic [2:0] CHROMA_NONE = 3'd0;
	localparam logic [2:0] CHROMA_I420 = 3'd1;
	localparam logic [2:0] CHROMA_Y41B = 3'd2;
	localparam logic [2:0] CHROMA_UYVY = 3'd3;
	localparam logic [2:0] CHROMA_YV12 = 3'd4;

	typedef struct packed {
		logic [7:0]  byte_out;
		logic        in_frame;
		logic        frame_start;
		logic        frame_end;
		logic        frame_abort;
		logic        lost_sync;
		logic [23:0] frame_length;
		logic        header_valid;
		logic [15:0] image_width;
		logic [15:0] image_height;
		logic [2:0]  chroma_format;
	} split_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic        m_tlast;
	logic [3:0]  m_tuser;

	jpeg_frame_splitter dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.m_tuser(m_tuser)
	);

	// parser copy
	logic [4:0]  phase_q;
	logic [7:0]  delay_q [3];
	logic [15:0] seg_left;
	logic [23:0] frame_bytes;
	logic        resync_q;
	jfs_pkg::jfs_hdr_t hdr_q;
	logic [3:0]  sof_idx;
	logic [1:0]  ncomp_q;
	logic [7:0]  samp_q [3];
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [2:0]  chroma_q;

	split_word_t expected_words[$];
	int tx_idle_pct, rx_stall_pct;
	int words_sent, words_checked, mismatches, frames_sent;
	int ends_seen, aborts_seen, lost_seen, headers_seen;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [2:0] chroma_of();
		int a, b, q;
		if (ncomp_q == 2'd1)
			return CHROMA_NONE;
		a = samp_q[0][7:4] * samp_q[0][3:0];
		b = samp_q[1][7:4] * samp_q[1][3:0];
		if (b == 0)
			return CHROMA_NONE;
		q = a / b;
		if (q == 4 && samp_q[0][3:0] == 4'd2) return CHROMA_I420;
		if (q == 4 && samp_q[0][3:0] == 4'd4) return CHROMA_Y41B;
		if (q == 2) return CHROMA_UYVY;
		if (q == 1) return CHROMA_YV12;
		return CHROMA_NONE;
	endfunction

	function automatic void capture_sof(logic [7:0] v);
		int i, k;
		i = sof_idx;
		if (i == 1) height_q[15:8] = v;
		else if (i == 2) height_q[7:0] = v;
		else if (i == 3) width_q[15:8] = v;
		else if (i == 4) width_q[7:0] = v;
		else if (i == 5) begin
			if (v != 8'd1 && v != 8'd3) begin
				hdr_q = jfs_pkg::HS_DONE;
				return;
			end
			ncomp_q = v[1:0];
		end else if (i >= 6 && i <= 14) begin
			k = i - 6;
			if (k % 3 == 1)
				samp_q[(k / 3) % jfs_pkg::MAX_COMPONENTS] = v;
		end
		if (i >= 6 && i == 5 + 3 * ncomp_q) begin
			chroma_q = chroma_of();
			hdr_q = jfs_pkg::HS_VALID;
			return;
		end
		sof_idx = sof_idx + 4'd1;
	endfunction

	function automatic void end_segment(bit sos);
		if (hdr_q == jfs_pkg::HS_IN_SOF)
			hdr_q = jfs_pkg::HS_DONE;
		phase_q = sos ? P_ENTROPY : P_MARK;
	endfunction

	function automatic void clear_parser();
		phase_q = P_HUNT;
		delay_q = '{8'd0, 8'd0, 8'd0};
		seg_left = '0;
		frame_bytes = '0;
		resync_q = 1'b0;
		hdr_q = jfs_pkg::HS_SEARCH;
		sof_idx = '0;
		ncomp_q = '0;
		samp_q = '{8'd0, 8'd0, 8'd0};
	endfunction

	function automatic split_word_t split_byte(bit flush, logic [7:0] b);
		split_word_t r;
		logic [7:0] x, l1, l2;
		logic [4:0] ph;
		logic [15:0] len;
		r = '0;
		if (flush) begin
			clear_parser();
			return r;
		end
		x = delay_q[0];
		l1 = delay_q[1];
		l2 = delay_q[2];
		delay_q = '{l1, l2, b};
		ph = (phase_q > P_STUFF) ? P_HUNT : phase_q;
		if ((ph == P_MARK || ph == P_MCODE || ph == P_ENTROPY) && x == jfs_pkg::MK_FILL &&
				l1 == jfs_pkg::MK_SOI) begin
			r.frame_abort = 1'b1;
			ph = P_HUNT;
		end
		phase_q = ph;
		if (ph == P_HUNT) begin
			if (x == jfs_pkg::MK_FILL && l1 == jfs_pkg::MK_SOI && l2 == jfs_pkg::MK_FILL) begin
				r.frame_start = 1'b1;
				r.in_frame = 1'b1;
				frame_bytes = 24'd1;
				phase_q = P_SOI2;
				hdr_q = jfs_pkg::HS_SEARCH;
				sof_idx = '0;
				resync_q = 1'b0;
				seg_left = '0;
			end
		end else begin
			r.in_frame = 1'b1;
			if (frame_bytes != '1)
				frame_bytes = frame_bytes + 24'd1;
			case (ph)
				P_SOI2: phase_q = P_MARK;
				P_MARK: begin
					if (x == jfs_pkg::MK_FILL) phase_q = P_MCODE;
					else if (!resync_q) begin
						r.lost_sync = 1'b1;
						resync_q = 1'b1;
					end
				end
				P_MCODE: begin
					if (x != jfs_pkg::MK_FILL) begin
						resync_q = 1'b0;
						if (x == jfs_pkg::MK_EOI) begin
							r.frame_end = 1'b1;
							r.frame_length = frame_bytes;
							phase_q = P_HUNT;
						end else if (x >= jfs_pkg::MK_RST_LO && x <= jfs_pkg::MK_RST_HI) begin
							phase_q = P_ENTROPY;
						end else if (x == jfs_pkg::MK_SOS) begin
							if (hdr_q == jfs_pkg::HS_SEARCH) hdr_q = jfs_pkg::HS_DONE;
							phase_q = P_SOS_LEN_HI;
						end else begin
							if (x == jfs_pkg::MK_SOF0 && hdr_q == jfs_pkg::HS_SEARCH) begin
								hdr_q = jfs_pkg::HS_IN_SOF;
								sof_idx = '0;
							end
							phase_q = P_LEN_HI;
						end
					end
				end
				P_LEN_HI, P_SOS_LEN_HI: begin
					seg_left = {x, 8'd0};
					phase_q = ph + 5'd1;
				end
				P_LEN_LO, P_SOS_LEN_LO: begin
					len = seg_left | {8'd0, x};
					seg_left = (len >= 16'd2) ? len - 16'd2 : 16'd0;
					if (seg_left == 0) end_segment(ph == P_SOS_LEN_LO);
					else phase_q = ph + 5'd1;
				end
				P_PAYLOAD, P_SOS_PAYLOAD: begin
					if (hdr_q == jfs_pkg::HS_IN_SOF && ph == P_PAYLOAD)
						capture_sof(x);
					if (seg_left != 0) seg_left = seg_left - 16'd1;
					if (seg_left == 0) end_segment(ph == P_SOS_PAYLOAD);
				end
				P_ENTROPY: begin
					if (x == jfs_pkg::MK_FILL)
						phase_q = (l1 == 8'd0) ? P_STUFF : P_MCODE;
				end
				default: phase_q = P_ENTROPY;
			endcase
		end
		r.byte_out = x;
		if (r.in_frame) begin
			r.header_valid = (hdr_q == jfs_pkg::HS_VALID);
			r.image_width = width_q;
			r.image_height = height_q;
			r.chroma_format = chroma_q;
		end
		return r;
	endfunction

	function automatic void compare_field(string name, longint unsigned want,
			longint unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch on word %0d, %s: expected %0h, got %0h",
					words_checked, name, want, got);
		end
	endfunction

	always @(negedge clk)
		m_tready <= ($urandom_range(99) >= rx_stall_pct);

	always @(posedge clk) begin
		split_word_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: tdata %0h", m_tdata);
			end else begin
				w = expected_words.pop_front();
				compare_field("byte_out", w.byte_out, m_tdata[7:0]);
				compare_field("frame_length", w.frame_length, m_tdata[31:8]);
				compare_field("header_valid", w.header_valid, m_tdata[32]);
				compare_field("image_width", w.image_width, m_tdata[48:33]);
				compare_field("image_height", w.image_height, m_tdata[64:49]);
				compare_field("chroma_format", w.chroma_format, m_tdata[67:65]);
				compare_field("fill", 0, m_tdata[71:68]);
				compare_field("frame_end", w.frame_end, m_tlast);
				compare_field("in_frame", w.in_frame, m_tuser[0]);
				compare_field("frame_start", w.frame_start, m_tuser[1]);
				compare_field("frame_abort", w.frame_abort, m_tuser[2]);
				compare_field("lost_sync", w.lost_sync, m_tuser[3]);
				ends_seen += w.frame_end;
				aborts_seen += w.frame_abort;
				lost_seen += w.lost_sync;
				headers_seen += w.frame_end & w.header_valid;
				words_checked++;
			end
		end
	end

	task automatic send_word(bit flush, logic [7:0] b);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = flush;
		s_tdata = b;
		do @(posedge clk); while (!s_tready);
		expected_words.push_back(split_byte(flush, b));
		words_sent++;
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic put(logic [7:0] b);
		send_word(1'b0, b);
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (expected_words.size() != 0)
			@(negedge clk);
	endtask

	// marker with optional fill bytes ahead of it
	task automatic put_marker(logic [7:0] code);
		put(jfs_pkg::MK_FILL);
		if ($urandom_range(9) == 0)
			repeat ($urandom_range(3, 1)) put(jfs_pkg::MK_FILL);
		put(code);
	endtask

	task automatic put_segment(logic [7:0] code, int len);
		put_marker(code);
		put(len[15:8]);
		put(len[7:0]);
		for (int i = 2; i < len; i++)
			put(8'($urandom_range(255)));
	endtask

	// trunc drops that many bytes off the end of the segment
	task automatic put_sof0(logic [15:0] h, logic [15:0] w, int nc, logic [7:0] s0,
			logic [7:0] s1, int trunc);
		logic [7:0] body[$];
		int len;
		body = '{8'd8, h[15:8], h[7:0], w[15:8], w[7:0], nc[7:0]};
		for (int c = 0; c < nc; c++) begin
			body.push_back(8'(c + 1));
			body.push_back(c == 0 ? s0 : s1);
			body.push_back(8'($urandom_range(3)));
		end
		len = body.size() + 2 - trunc;
		put_marker(jfs_pkg::MK_SOF0);
		put(len[15:8]);
		put(len[7:0]);
		for (int i = 0; i < len - 2; i++)
			put(body[i]);
	endtask

	task automatic put_entropy(int n);
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(19))
				0: begin
					put(jfs_pkg::MK_FILL);
					put(8'h00);
				end
				1: put_marker(jfs_pkg::MK_RST_LO + 8'($urandom_range(7)));
				default: put(8'($urandom_range(254)));
			endcase
		end
	endtask

	task automatic put_sos_scan(int n);
		put_segment(jfs_pkg::MK_SOS, 8);
		put_entropy(n);
	endtask

	task automatic put_frame(logic [15:0] h, logic [15:0] w, int nc, logic [7:0] s0,
			logic [7:0] s1, int trunc, int scan_len);
		put(jfs_pkg::MK_FILL);
		put(jfs_pkg::MK_SOI);
		put_segment(MK_APP0, $urandom_range(2, 8));
		put_sof0(h, w, nc, s0, s1, trunc);
		if (trunc != 0)
			put_segment(MK_DQT, 3);
		put_sos_scan(scan_len);
		put_marker(jfs_pkg::MK_EOI);
		frames_sent++;
	endtask

	function automatic logic [7:0] pick_sampling();
		case ($urandom_range(6))
			0: return 8'h22;
			1: return 8'h21;
			2: return 8'h14;
			3: return 8'h11;
			4: return 8'h00;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic test_directed();
		put_frame(16'hffff, 16'h0000, 3, 8'h22, 8'h11, 0, 4);
		put_frame(16'h0000, 16'hffff, 3, 8'h14, 8'h11, 0, 4);
		put_frame(16'h1234, 16'h5678, 3, 8'h21, 8'h11, 0, 3);
		put_frame(16'h0040, 16'h0080, 3, 8'h11, 8'h11, 0, 3);
		// zero factors on component 1
		put_frame(16'h0010, 16'h0010, 3, 8'h22, 8'h00, 0, 3);
		put_frame(16'h0020, 16'h0030, 1, 8'h22, 8'h00, 0, 3);
		// bad component count, then a truncated header
		put_frame(16'h0021, 16'h0031, 2, 8'h22, 8'h11, 0, 3);
		put_frame(16'habcd, 16'h1357, 3, 8'h22, 8'h11, 4, 3);
		// short length fields and no header at all
		put(jfs_pkg::MK_FILL);
		put(jfs_pkg::MK_SOI);
		put_segment(MK_APP0, 0);
		put_segment(MK_APP0 + 8'd1, 1);
		put_sos_scan(3);
		put_marker(jfs_pkg::MK_EOI);
		// lost sync, then abort by a new start of image inside entropy data
		put(jfs_pkg::MK_FILL);
		put(jfs_pkg::MK_SOI);
		put(8'h42);
		put(8'h43);
		put_segment(MK_APP0, 4);
		put_sos_scan(3);
		put(jfs_pkg::MK_FILL);
		put(jfs_pkg::MK_SOI);
		put_segment(MK_DQT, 4);
		put_marker(jfs_pkg::MK_EOI);
		// flush in the middle of a frame
		put(jfs_pkg::MK_FILL);
		put(jfs_pkg::MK_SOI);
		put_segment(MK_APP0, 5);
		send_word(1'b1, 8'hff);
		put_frame(16'h0002, 16'h0002, 1, 8'h11, 8'h11, 0, 2);
		put(8'h00);
		put(8'h00);
		put(8'h00);
	endtask

	task automatic test_random_stream(int budget);
		int stop_at;
		stop_at = words_sent + budget;
		while (words_sent < stop_at) begin
			case ($urandom_range(19))
				0: repeat ($urandom_range(6, 1)) put(8'($urandom_range(255)));
				1: send_word(1'b1, 8'($urandom_range(255)));
				2: begin
					// broken frame: garbage where a marker should be
					put(jfs_pkg::MK_FILL);
					put(jfs_pkg::MK_SOI);
					repeat ($urandom_range(3, 1)) put(8'($urandom_range(254)));
					put_segment(MK_APP0, $urandom_range(0, 6));
					put_sos_scan($urandom_range(1, 6));
					put_marker(jfs_pkg::MK_EOI);
				end
				3: begin
					// aborted frame restarted right away
					put(jfs_pkg::MK_FILL);
					put(jfs_pkg::MK_SOI);
					put_segment(MK_APP0, $urandom_range(2, 6));
					if ($urandom_range(1)) put_sos_scan($urandom_range(1, 5));
					put(jfs_pkg::MK_FILL);
					put(jfs_pkg::MK_SOI);
					put_sos_scan($urandom_range(1, 5));
					put_marker(jfs_pkg::MK_EOI);
				end
				default: put_frame(16'($urandom_range(65535)), 16'($urandom_range(65535)),
					($urandom_range(9) == 0) ? $urandom_range(4) : (2 * $urandom_range(1) + 1),
					pick_sampling(), pick_sampling(),
					($urandom_range(7) == 0) ? $urandom_range(1, 6) : 0,
					$urandom_range(1, 12));
			endcase
		end
	endtask

	task automatic test_idling_phases();
		int tx_pct[4] = '{0, 63, 0, 21};
		int rx_pct[4] = '{0, 0, 63, 21};
		for (int p = 0; p < 4; p++) begin
			tx_idle_pct = tx_pct[p];
			rx_stall_pct = rx_pct[p];
			test_random_stream(420);
			wait_drained();
		end
		tx_idle_pct = 0;
		rx_stall_pct = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		m_tready = 1'b0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		words_sent = 0;
		words_checked = 0;
		mismatches = 0;
		frames_sent = 0;
		ends_seen = 0;
		aborts_seen = 0;
		lost_seen = 0;
		headers_seen = 0;
		width_q = '0;
		height_q = '0;
		chroma_q = '0;
		clear_parser();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		wait_drained();
		test_idling_phases();
		wait_drained();
		repeat (20) @(posedge clk);
		$display("sent %0d words in %0d generated frames, %0d results checked",
			words_sent, frames_sent, words_checked);
		$display("frame ends %0d (with header %0d), aborts %0d, lost sync %0d",
			ends_seen, headers_seen, aborts_seen, lost_seen);
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/jfs_pkg.sv
rtl/jfs_datapath.sv
rtl/jfs_ctrl.sv
rtl/jpeg_frame_splitter.sv
test/tb_top.sv
